// ===== hw/rtl/fbde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fbde_pkg;

  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned PIX_W      = COLOR_W + LEVEL_W;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned LEN_W      = 10;
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned FW_W       = 8;
  localparam int unsigned FH_W       = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CW         = 14;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET    = 3'd0,
    REQ_FILL   = 3'd1,
    REQ_PILLAR = 3'd2,
    REQ_CLEAR  = 3'd3,
    REQ_READ   = 3'd4
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH      = 3'd0,
    CFG_HEIGHT     = 3'd1,
    CFG_FORE_COLOR = 3'd2,
    CFG_FORE_LEVEL = 3'd3,
    CFG_BACK_COLOR = 3'd4,
    CFG_BACK_LEVEL = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_BOUND,
    ST_CLIP,
    ST_BASE,
    ST_FILL,
    ST_RDREQ,
    ST_RDDATA,
    ST_DONE
  } state_e;

  localparam logic [FW_W-1:0]    RST_WIDTH      = 8'd128;
  localparam logic [FH_W-1:0]    RST_HEIGHT     = 7'd64;
  localparam logic [COLOR_W-1:0] RST_FORE_COLOR = 4'd7;
  localparam logic [LEVEL_W-1:0] RST_FORE_LEVEL = 8'd1;
  localparam logic [COLOR_W-1:0] RST_BACK_COLOR = 4'd0;
  localparam logic [LEVEL_W-1:0] RST_BACK_LEVEL = 8'd0;

endpackage

`default_nettype wire

// ===== hw/rtl/frame_buffer_draw_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One pixel per cycle through the single port of the pixel memory.
// One command in flight; the next is taken once its result is registered.
// Reset loads the register defaults, then sweeps all MAX_WIDTH * MAX_HEIGHT locations
// (8192 by default) painting the default clear pattern while commands are stalled.

module frame_buffer_draw_engine #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fbde_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fbde_pkg::CFG_DATA_W-1:0]      cfg_data_i,

  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [fbde_pkg::REQ_W-1:0]           req_type_i,
  input  logic signed [fbde_pkg::COORD_W-1:0]  x_a_i,
  input  logic signed [fbde_pkg::COORD_W-1:0]  y_a_i,
  input  logic signed [fbde_pkg::COORD_W-1:0]  x_b_i,
  input  logic signed [fbde_pkg::COORD_W-1:0]  y_b_i,
  input  logic [fbde_pkg::LEN_W-1:0]           pillar_length_i,
  input  logic [fbde_pkg::COLOR_W-1:0]         color_value_i,
  input  logic [fbde_pkg::LEVEL_W-1:0]         brightness_value_i,

  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [fbde_pkg::COLOR_W-1:0]         read_color_o,
  output logic [fbde_pkg::LEVEL_W-1:0]         read_brightness_o,
  output logic                                 out_of_range_o,
  output logic                                 done_res_o
);

  import fbde_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW    = HW + WW;
  localparam int unsigned W0    = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
  localparam int unsigned H0    = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;
  localparam int unsigned INIT_BACK_END = W0 * (H0 / 2);
  localparam int unsigned INIT_FORE_END = W0 * H0;

  // configuration
  logic [FW_W-1:0]    fw_q;
  logic [FH_W-1:0]    fh_q;
  logic [COLOR_W-1:0] fore_col_q, back_col_q;
  logic [LEVEL_W-1:0] fore_lvl_q, back_lvl_q;

  // control
  state_e        state_q, state_d;
  logic [AW-1:0] init_q, init_d;
  logic          out_valid_q, out_valid_d;

  // command and sweep
  logic [REQ_W-1:0]          req_q;
  logic signed [COORD_W-1:0] xa_q, ya_q, xb_q, yb_q;
  logic [LEN_W-1:0]          len_q;
  logic [COLOR_W-1:0]        col_q;
  logic [LEVEL_W-1:0]        lvl_q;
  coord_t                    bx0_q, bx1_q, by0_q, by1_q;
  coord_t                    bx0_d, bx1_d, by0_d, by1_d;
  logic [WW-1:0]             cx0_q, cx1_q;
  logic [HW-1:0]             cy0_q, cy1_q;
  logic                      empty_q, empty_d;
  logic [AW-1:0]             base_q, base_d;
  logic [WW-1:0]             x_q, x_d;
  logic [HW-1:0]             y_q, y_d;
  logic [PIX_W-1:0]          rd_q;
  logic [COLOR_W-1:0]        oc_q;
  logic [LEVEL_W-1:0]        ob_q;
  logic                      oor_q;

  // derived
  logic [31:0]    fw_ext, fh_ext;
  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;
  logic [HW-1:0]  mid;
  coord_t         w_s, h_s;
  logic [LEN_W:0] pn, half_n;
  logic           pn_full;
  coord_t         cx0_c, cx1_c, cy0_c, cy1_c;
  logic [PW-1:0]  prod;
  logic [WW-1:0]  x_inc;
  logic [HW-1:0]  y_inc;
  logic           in_acc, out_load, is_read;

  // memory port
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= RST_WIDTH;
      fh_q       <= RST_HEIGHT;
      fore_col_q <= RST_FORE_COLOR;
      fore_lvl_q <= RST_FORE_LEVEL;
      back_col_q <= RST_BACK_COLOR;
      back_lvl_q <= RST_BACK_LEVEL;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:      fw_q       <= cfg_data_i[FW_W-1:0];
        CFG_HEIGHT:     fh_q       <= cfg_data_i[FH_W-1:0];
        CFG_FORE_COLOR: fore_col_q <= cfg_data_i[COLOR_W-1:0];
        CFG_FORE_LEVEL: fore_lvl_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_BACK_COLOR: back_col_q <= cfg_data_i[COLOR_W-1:0];
        CFG_BACK_LEVEL: back_lvl_q <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = 32'(fw_q);
    if (fw_ext == 32'd0) begin
      fw_ext = 32'd1;
    end else if (fw_ext > 32'(MAX_WIDTH)) begin
      fw_ext = 32'(MAX_WIDTH);
    end
    fh_ext = 32'(fh_q);
    if (fh_ext == 32'd0) begin
      fh_ext = 32'd1;
    end else if (fh_ext > 32'(MAX_HEIGHT)) begin
      fh_ext = 32'(MAX_HEIGHT);
    end
  end

  assign eff_w = fw_ext[WW-1:0];
  assign eff_h = fh_ext[HW-1:0];
  assign mid   = eff_h >> 1;
  assign w_s   = CW'(eff_w);
  assign h_s   = CW'(eff_h);

  // column length matched to height parity, clamped at the height
  assign pn      = {1'b0, len_q} + (LEN_W + 1)'(len_q[0] ^ eff_h[0]);
  assign pn_full = 32'(pn) >= 32'(eff_h);
  assign half_n  = pn_full ? (LEN_W + 1)'(mid) : (pn >> 1);

  always_comb begin
    bx0_d = '0;
    bx1_d = '0;
    by0_d = '0;
    by1_d = '0;
    unique case (req_q)
      REQ_SET, REQ_READ: begin
        bx0_d = CW'(xa_q);
        bx1_d = CW'(xa_q) + CW'(1);
        by0_d = CW'(ya_q);
        by1_d = CW'(ya_q) + CW'(1);
      end
      REQ_FILL: begin
        bx0_d = CW'(xa_q);
        bx1_d = CW'(xb_q);
        by0_d = CW'(ya_q);
        by1_d = CW'(yb_q);
      end
      REQ_PILLAR: begin
        bx0_d = CW'(xa_q);
        bx1_d = CW'(xa_q) + CW'(1);
        by0_d = pn_full ? '0 : (CW'(mid) - CW'(half_n) + CW'(1));
        // a single-row frame still gets row 0
        by1_d = (pn_full && (mid == '0)) ? CW'(1) : (CW'(mid) + CW'(half_n));
      end
      REQ_CLEAR: begin
        bx1_d = w_s;
        by1_d = h_s;
      end
      default: ;
    endcase
  end

  assign cx0_c   = bx0_q[CW-1] ? '0 : bx0_q;
  assign cy0_c   = by0_q[CW-1] ? '0 : by0_q;
  assign cx1_c   = (bx1_q > w_s) ? w_s : bx1_q;
  assign cy1_c   = (by1_q > h_s) ? h_s : by1_q;
  assign empty_d = (cx0_c >= cx1_c) || (cy0_c >= cy1_c);

  assign prod  = PW'(cy0_q) * PW'(eff_w);
  assign x_inc = x_q + WW'(1);
  assign y_inc = y_q + HW'(1);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_read    = (req_q == REQ_READ);

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_load    = 1'b0;
    base_d      = base_q;
    x_d         = x_q;
    y_d         = y_q;
    ram_we      = 1'b0;
    ram_addr    = base_q + AW'(x_q[XW-1:0]);
    ram_wdata   = {col_q, lvl_q};
    unique case (state_q)
      ST_INIT: begin
        ram_we   = 1'b1;
        ram_addr = init_q;
        if (32'(init_q) < INIT_BACK_END) begin
          ram_wdata = {RST_BACK_COLOR, RST_BACK_LEVEL};
        end else if (32'(init_q) < INIT_FORE_END) begin
          ram_wdata = {RST_FORE_COLOR, RST_FORE_LEVEL};
        end else begin
          ram_wdata = '0;
        end
        init_d = init_q + AW'(1);
        if (init_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_BOUND;
        end
      end
      ST_BOUND: state_d = ST_CLIP;
      ST_CLIP:  state_d = ST_BASE;
      ST_BASE: begin
        base_d = AW'(prod);
        x_d    = cx0_q;
        y_d    = cy0_q;
        if (empty_q) begin
          state_d = ST_DONE;
        end else if (is_read) begin
          state_d = ST_RDREQ;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (req_q == REQ_CLEAR) begin
          ram_wdata = (y_q >= mid) ? {fore_col_q, fore_lvl_q} : {back_col_q, back_lvl_q};
        end
        if (x_inc == cx1_q) begin
          x_d    = cx0_q;
          y_d    = y_inc;
          base_d = base_q + AW'(eff_w);
          if (y_inc == cy1_q) begin
            state_d = ST_DONE;
          end
        end else begin
          x_d = x_inc;
        end
      end
      ST_RDREQ:  state_d = ST_RDDATA;
      ST_RDDATA: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= req_type_i;
      xa_q  <= x_a_i;
      ya_q  <= y_a_i;
      xb_q  <= x_b_i;
      yb_q  <= y_b_i;
      len_q <= pillar_length_i;
      col_q <= color_value_i;
      lvl_q <= brightness_value_i;
    end
    if (state_q == ST_BOUND) begin
      bx0_q <= bx0_d;
      bx1_q <= bx1_d;
      by0_q <= by0_d;
      by1_q <= by1_d;
    end
    if (state_q == ST_CLIP) begin
      cx0_q   <= WW'(cx0_c);
      cx1_q   <= WW'(cx1_c);
      cy0_q   <= HW'(cy0_c);
      cy1_q   <= HW'(cy1_c);
      empty_q <= empty_d;
    end
    if (state_q == ST_RDDATA) begin
      rd_q <= ram_rdata;
    end
    if (out_load) begin
      oc_q  <= (is_read && !empty_q) ? rd_q[PIX_W-1:LEVEL_W] : '0;
      ob_q  <= (is_read && !empty_q) ? rd_q[LEVEL_W-1:0] : '0;
      oor_q <= is_read && empty_q;
    end
    base_q <= base_d;
    x_q    <= x_d;
    y_q    <= y_d;
  end

  fbde_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign read_color_o      = oc_q;
  assign read_brightness_o = ob_q;
  assign out_of_range_o    = oor_q;
  assign done_res_o        = 1'b1;

  a_fill_addr_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (32'(ram_addr) < DEPTH))
    else $error("fill address beyond pixel store");

  a_fill_x_in_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> ((x_q >= cx0_q) && (x_q < cx1_q) && (y_q < cy1_q)))
    else $error("fill sweep left the clipped rectangle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result registered outside completion");

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_INIT) || (state_q == ST_FILL)))
    else $error("pixel write outside init or fill");

  a_init_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> (in_stall_o && !out_valid_q))
    else $error("command taken during store initialisation");

endmodule

`default_nettype wire

// ===== hw/rtl/fbde_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fbde_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 8192,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire
